[rtl/core/utf8_text_width_meter_assert.svh]
// Assertion macros used by the UTF-8 text width meter checker.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef UTF8_TEXT_WIDTH_METER_ASSERT_SVH
`define UTF8_TEXT_WIDTH_METER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define UTF8TW_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define UTF8TW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define UTF8TW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/utf8tw_pkg.sv]
// Package for the UTF-8 text width meter: widths, constants, shared types
// and the column width function. Depends on nothing.
`default_nettype none

package utf8tw_pkg;

   localparam int COUNT_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int CP_BITS    = 21;
   localparam int INC_BITS   = 3;

   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   // Byte class masks and patterns.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   localparam logic [CP_BITS-1:0] CTRL_LOW_END  = 21'h00020;
   localparam logic [CP_BITS-1:0] CTRL_HIGH_LO  = 21'h0007F;
   localparam logic [CP_BITS-1:0] CTRL_HIGH_END = 21'h000A0;

   typedef struct packed {
      logic [CP_BITS-1:0] partial;
      logic [1:0]         needed;
      logic [1:0]         pending;
   } seq_state_type;

   typedef struct packed {
      seq_state_type       next_seq;
      logic [INC_BITS-1:0] cp_inc;
      logic [INC_BITS-1:0] w_inc;
      logic                emit;
   } decode_out_type;

   function automatic logic in_range(logic [CP_BITS-1:0] cp, logic [CP_BITS-1:0] lo,
                                     logic [CP_BITS-1:0] hi);
      return (cp >= lo) && (cp <= hi);
   endfunction

   // Terminal column width of one code point: 0, 1 or 2.
   function automatic logic [1:0] col_width(logic [CP_BITS-1:0] cp);
      logic wide;
      wide = in_range(cp, 21'h01100, 21'h0115F) || in_range(cp, 21'h02329, 21'h0232A) ||
             in_range(cp, 21'h02E80, 21'h0A4CF) || in_range(cp, 21'h0AC00, 21'h0D7A3) ||
             in_range(cp, 21'h0F900, 21'h0FAFF) || in_range(cp, 21'h0FE10, 21'h0FE19) ||
             in_range(cp, 21'h0FE30, 21'h0FE6F) || in_range(cp, 21'h0FF00, 21'h0FF60) ||
             in_range(cp, 21'h0FFE0, 21'h0FFE6) || in_range(cp, 21'h1F300, 21'h1FAFF) ||
             in_range(cp, 21'h20000, 21'h3FFFD);
      if ((cp < CTRL_LOW_END) || ((cp >= CTRL_HIGH_LO) && (cp < CTRL_HIGH_END))) begin
         return 2'd0;
      end
      return wide ? 2'd2 : 2'd1;
   endfunction

endpackage

`default_nettype wire

[rtl/core/utf8tw_if.sv]
// Channel interfaces of the UTF-8 text width meter: byte requests in, totals out.
// Depends on nothing.
`default_nettype none

interface utf8tw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_text;

   modport source (output valid, data_byte, byte_present, end_of_text, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_text, output ready);
endinterface

interface utf8tw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] codepoint_count;
   logic [31:0] column_total;

   modport source (output valid, codepoint_count, column_total, input ready);
   modport sink (input valid, codepoint_count, column_total, output ready);
endinterface

`default_nettype wire

[rtl/core/utf8tw_decode.sv]
// UTF-8 decode step: from the open sequence state and one request, the next
// sequence state and the count and width increments. Uses utf8tw_pkg.
`default_nettype none

module utf8tw_decode (
   input  var utf8tw_pkg::seq_state_type  seq,
   input  var logic [7:0]                 data_byte,
   input  var logic                       byte_present,
   input  var logic                       end_of_text,
   output utf8tw_pkg::decode_out_type     dec
);

   logic [utf8tw_pkg::CP_BITS-1:0] joined_cp;
   logic                           is_cont;

   assign joined_cp = {seq.partial[utf8tw_pkg::CP_BITS-7:0], data_byte[5:0]};
   assign is_cont   = (data_byte & utf8tw_pkg::CONT_MASK) == utf8tw_pkg::CONT_CODE;

   always_comb begin
      utf8tw_pkg::seq_state_type           s;
      logic [utf8tw_pkg::INC_BITS-1:0]     cp_inc;
      logic [utf8tw_pkg::INC_BITS-1:0]     w_inc;
      logic                                fresh;
      s      = seq;
      cp_inc = '0;
      w_inc  = '0;
      fresh  = 1'b1;
      if (byte_present) begin
         if (s.pending != 2'd0) begin
            if (is_cont) begin
               fresh = 1'b0;
               if (s.needed <= 2'd1) begin
                  cp_inc = 3'd1;
                  w_inc  = {1'b0, utf8tw_pkg::col_width(joined_cp)};
                  s      = '0;
               end else begin
                  s.partial = joined_cp;
                  s.needed  = s.needed - 2'd1;
                  s.pending = s.pending + 2'd1;
               end
            end else begin
               // Broken sequence: each byte seen so far is one narrow code point.
               cp_inc = {1'b0, s.pending};
               w_inc  = {1'b0, s.pending};
               s      = '0;
            end
         end
         if (fresh) begin
            if (!data_byte[7]) begin
               cp_inc = cp_inc + 3'd1;
               w_inc  = w_inc + {1'b0, utf8tw_pkg::col_width({13'd0, data_byte})};
            end else if ((data_byte & utf8tw_pkg::LEAD2_MASK) == utf8tw_pkg::LEAD2_CODE) begin
               s.partial = {16'd0, data_byte[4:0]};
               s.needed  = 2'd1;
               s.pending = 2'd1;
            end else if ((data_byte & utf8tw_pkg::LEAD3_MASK) == utf8tw_pkg::LEAD3_CODE) begin
               s.partial = {17'd0, data_byte[3:0]};
               s.needed  = 2'd2;
               s.pending = 2'd1;
            end else if ((data_byte & utf8tw_pkg::LEAD4_MASK) == utf8tw_pkg::LEAD4_CODE) begin
               s.partial = {18'd0, data_byte[2:0]};
               s.needed  = 2'd3;
               s.pending = 2'd1;
            end else begin
               cp_inc = cp_inc + 3'd1;
               w_inc  = w_inc + 3'd1;
            end
         end
      end
      if (end_of_text) begin
         // A truncated sequence counts its bytes as narrow code points.
         cp_inc = cp_inc + {1'b0, s.pending};
         w_inc  = w_inc + {1'b0, s.pending};
         s      = '0;
      end
      dec.next_seq = s;
      dec.cp_inc   = cp_inc;
      dec.w_inc    = w_inc;
      dec.emit     = end_of_text;
   end

endmodule

`default_nettype wire

[rtl/core/utf8tw_totals.sv]
// Saturating code point and width counters, cleared after each text, with the
// clamped totals for the result register. Uses utf8tw_pkg.
`default_nettype none

module utf8tw_totals (
   input  var logic                            clock,
   input  var logic                            reset,
   input  var logic                            step,
   input  var utf8tw_pkg::decode_out_type      dec,
   output logic [utf8tw_pkg::OUT_BITS-1:0]     cp_total,
   output logic [utf8tw_pkg::OUT_BITS-1:0]     w_total
);

   localparam int CB = utf8tw_pkg::COUNT_BITS;

   logic [CB-1:0] cp_count_ff, cp_count_in;
   logic [CB-1:0] w_count_ff, w_count_in;
   logic [CB:0]   cp_sum, w_sum;
   logic [CB-1:0] cp_next, w_next;

   assign cp_sum  = {1'b0, cp_count_ff} + (CB+1)'(dec.cp_inc);
   assign w_sum   = {1'b0, w_count_ff} + (CB+1)'(dec.w_inc);
   assign cp_next = cp_sum[CB] ? '1 : cp_sum[CB-1:0];
   assign w_next  = w_sum[CB] ? '1 : w_sum[CB-1:0];

   assign cp_total = (cp_next > CB'(utf8tw_pkg::OUT_MAX)) ? utf8tw_pkg::OUT_MAX
                                                          : utf8tw_pkg::OUT_BITS'(cp_next);
   assign w_total  = (w_next > CB'(utf8tw_pkg::OUT_MAX)) ? utf8tw_pkg::OUT_MAX
                                                         : utf8tw_pkg::OUT_BITS'(w_next);

   always_comb begin
      cp_count_in = cp_count_ff;
      w_count_in  = w_count_ff;
      if (step) begin
         cp_count_in = dec.emit ? '0 : cp_next;
         w_count_in  = dec.emit ? '0 : w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_count_ff <= '0;
         w_count_ff  <= '0;
      end else begin
         cp_count_ff <= cp_count_in;
         w_count_ff  <= w_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/utf8_text_width_meter.sv]
// A request is registered at acceptance and its result, if any, is registered in the
// result register when the held end-of-text request is decoded.
// Throughput: one request per cycle; only an end-of-text request held in the input
// register waits, and only while an earlier result has not been taken.
// Reset (synchronous, active high) clears the counters, the open sequence and both
// valid flags.
`default_nettype none

module utf8_text_width_meter (
   input  var logic     clock,
   input  var logic     reset,
   utf8tw_req_if.sink   req_channel,
   utf8tw_rsp_if.source rsp_channel
);

   // Input register: one request waiting to be decoded.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_present_ff, in_present_in;
   logic       in_last_ff, in_last_in;

   // Open multibyte sequence carried from one byte to the next.
   utf8tw_pkg::seq_state_type seq_ff, seq_in;

   // Result register.
   logic                             out_valid_ff, out_valid_in;
   logic [utf8tw_pkg::OUT_BITS-1:0]  out_cp_ff, out_cp_in;
   logic [utf8tw_pkg::OUT_BITS-1:0]  out_w_ff, out_w_in;

   utf8tw_pkg::decode_out_type       dec;
   logic [utf8tw_pkg::OUT_BITS-1:0]  cp_total, w_total;
   logic                             out_free;
   logic                             step;
   logic                             req_take;

   // The result slot frees up in the same cycle the consumer takes it, so a
   // stream of texts runs without bubbles. Ordinary bytes never wait for it.
   assign out_free = !out_valid_ff || rsp_channel.ready;
   assign step     = in_valid_ff && (!in_last_ff || out_free);
   assign req_channel.ready = !in_valid_ff || step;
   assign req_take = req_channel.valid && req_channel.ready;

   utf8tw_decode u_decode (
      .seq          (seq_ff),
      .data_byte    (in_byte_ff),
      .byte_present (in_present_ff),
      .end_of_text  (in_last_ff),
      .dec          (dec)
   );

   utf8tw_totals u_totals (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .dec      (dec),
      .cp_total (cp_total),
      .w_total  (w_total)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_present_in = in_present_ff;
      in_last_in    = in_last_ff;
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_byte_in    = req_channel.data_byte;
         in_present_in = req_channel.byte_present;
         in_last_in    = req_channel.end_of_text;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // The sequence state moves only when the held request is decoded.
   assign seq_in = step ? dec.next_seq : seq_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_w_in     = out_w_ff;
      if (step && dec.emit) begin
         out_valid_in = 1'b1;
         out_cp_in    = cp_total;
         out_w_in     = w_total;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_present_ff <= in_present_in;
      in_last_ff    <= in_last_in;
      out_cp_ff     <= out_cp_in;
      out_w_ff      <= out_w_in;
   end

   assign rsp_channel.valid           = out_valid_ff;
   assign rsp_channel.codepoint_count = out_cp_ff;
   assign rsp_channel.column_total    = out_w_ff;

endmodule

`default_nettype wire

[rtl/core/utf8tw_checker.sv]
// Port-level checks for the UTF-8 text width meter, bound to the top level.
// Uses the macros of utf8_text_width_meter_assert.svh.
`default_nettype none

`include "utf8_text_width_meter_assert.svh"

module utf8tw_checker (
   input var logic        clock,
   input var logic        reset,
   input var logic        req_ready,
   input var logic        rsp_valid,
   input var logic        rsp_ready,
   input var logic [31:0] rsp_codepoint_count,
   input var logic [31:0] rsp_column_total
);

   `UTF8TW_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column_total), "result dropped or changed while stalled")
   `UTF8TW_ASSERT_SAME(a_ready_when_out_empty, !rsp_valid, req_ready, "request stalled with no result waiting")
   `UTF8TW_ASSERT_SAME(a_width_bound, rsp_valid, {1'b0, rsp_column_total} <= {rsp_codepoint_count, 1'b0}, "width exceeds two columns per code point")
   `UTF8TW_ASSERT_ALWAYS(a_idle_after_reset, !$fell(reset) || !rsp_valid, "result present right after reset")

endmodule

bind utf8_text_width_meter utf8tw_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_channel.ready),
   .rsp_valid           (rsp_channel.valid),
   .rsp_ready           (rsp_channel.ready),
   .rsp_codepoint_count (rsp_channel.codepoint_count),
   .rsp_column_total    (rsp_channel.column_total)
);

`default_nettype wire
